>>> rtl/stt_pkg.sv
// Shared types, constants and helper functions for the source text tokenizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int POS_BITS = 16;
  localparam int KEYWORD_MAX = 12;
  localparam int LEN_BITS = 16;
  localparam int KW_COUNT = 15;
  localparam int KIDX_BITS = $clog2(KEYWORD_MAX + 1);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  // Token kind codes.
  localparam logic [4:0] K_END = 5'd0;
  localparam logic [4:0] K_IDENT = 5'd1;
  localparam logic [4:0] K_NUMBER = 5'd2;
  localparam logic [4:0] K_STRING = 5'd3;
  localparam logic [4:0] K_BAD = 5'd4;
  localparam logic [4:0] K_NE = 5'd5;
  localparam logic [4:0] K_EQEQ = 5'd6;
  localparam logic [4:0] K_GE = 5'd7;
  localparam logic [4:0] K_LE = 5'd8;
  localparam logic [4:0] K_ASSIGN = 5'd9;
  localparam logic [4:0] K_GT = 5'd10;
  localparam logic [4:0] K_LT = 5'd11;
  localparam logic [4:0] K_PLUS = 5'd12;
  localparam logic [4:0] K_MINUS = 5'd13;
  localparam logic [4:0] K_STAR = 5'd14;
  localparam logic [4:0] K_SLASH = 5'd15;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_STR,
    MODE_OP
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_item_t;

  // One or two tokens caused by one input byte, passed front to back.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } tok_pair_t;

  typedef logic [KEYWORD_MAX*8-1:0] word_t;

  // Keyword text, first letter in the low byte.
  function automatic word_t kw_text(input int i);
    word_t w;
    w = '0;
    unique case (i)
      0: w[47:0] = {"y", "e", "k", "w", "o", "l"};
      1: w[39:0] = {"p", "a", "c", "o", "n"};
      2: w[23:0] = {"p", "a", "c"};
      3: w[23:0] = {"s", "u", "s"};
      4: w[31:0] = {"p", "o", "l", "f"};
      5: w[95:0] = {"g", "n", "i", "d", "n", "i", "r", "g", "p", "e", "e", "k"};
      6: w[23:0] = {"p", "a", "y"};
      7: w[31:0] = {"x", "e", "l", "f"};
      8: w[15:0] = {"r", "f"};
      9: w[63:0] = {"g", "n", "i", "t", "s", "o", "h", "g"};
      10: w[55:0] = {"s", "e", "m", "o", "c", "e", "b"};
      11: w[55:0] = {"a", "r", "u", "a", "s", "a", "h"};
      12: w[63:0] = {"a", "r", "u", "a", "e", "s", "o", "l"};
      13: w[55:0] = {"d", "e", "k", "c", "a", "t", "s"};
      default: w[55:0] = {"d", "e", "o", "i", "t", "a", "r"};
    endcase
    return w;
  endfunction

  function automatic logic [KIDX_BITS-1:0] kw_len(input int i);
    unique case (i)
      0: return KIDX_BITS'(6);
      1: return KIDX_BITS'(5);
      2, 3, 6: return KIDX_BITS'(3);
      4, 7: return KIDX_BITS'(4);
      5: return KIDX_BITS'(12);
      8: return KIDX_BITS'(2);
      9, 12: return KIDX_BITS'(8);
      default: return KIDX_BITS'(7);
    endcase
  endfunction

  function automatic logic [4:0] kw_kind(input int i);
    unique case (i)
      10: return K_ASSIGN;
      11: return K_PLUS;
      12: return K_MINUS;
      13: return K_STAR;
      14: return K_SLASH;
      default: return 5'(16 + i);
    endcase
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
    if (POS_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
    return 16'(v);
  endfunction

endpackage

>>> rtl/stt_front.sv
// Scanner front end: accepts bytes, tracks the scan state and forms tokens.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  stt_pkg::in_item_t  in_item,
  output logic               tok_valid,
  output stt_pkg::tok_pair_t tok
);

  stt_pkg::scan_mode_t mode, mode_next;
  logic [7:0] pending_operator, pending_operator_next;
  logic [stt_pkg::POS_BITS-1:0] position_counter, position_counter_next;
  logic [stt_pkg::POS_BITS-1:0] token_start, token_start_next;
  logic [stt_pkg::LEN_BITS-1:0] token_count_len, token_count_len_next;
  logic [7:0] word_buffer [stt_pkg::KEYWORD_MAX];
  logic wb_we;
  logic [stt_pkg::KIDX_BITS-1:0] wb_addr;
  logic [7:0] c;
  logic is_end;
  stt_pkg::word_t word_flat;
  logic [4:0] wkind;
  logic [stt_pkg::LEN_BITS-1:0] len_inc;
  logic [stt_pkg::POS_BITS-1:0] p;

  // Results built this cycle.
  logic        n_flush, n_start, n_end;
  stt_pkg::out_item_t flush_tok, start_tok, end_tok, direct_tok;
  logic        flush_ok, start_emit, direct_ok;

  assign c = in_item.char_byte;
  assign p = position_counter;
  assign len_inc = (token_count_len == stt_pkg::LEN_MAX) ? token_count_len
                   : token_count_len + 1'b1;

  // Parallel keyword compare; unwritten entries sit past the word length.
  always_comb begin
    word_flat = '0;
    for (int i = 0; i < stt_pkg::KEYWORD_MAX; i++) begin
      if (i < int'(token_count_len)) word_flat[i*8 +: 8] = word_buffer[i];
    end
    wkind = stt_pkg::K_IDENT;
    if (token_count_len <= stt_pkg::LEN_BITS'(stt_pkg::KEYWORD_MAX)) begin
      for (int i = stt_pkg::KW_COUNT - 1; i >= 0; i--) begin
        if (stt_pkg::LEN_BITS'(stt_pkg::kw_len(i)) == token_count_len &&
            stt_pkg::kw_text(i) == word_flat) begin
          wkind = stt_pkg::kw_kind(i);
        end
      end
    end
  end

  // Token that a pending scan state turns into when it is flushed.
  always_comb begin
    flush_tok = '0;
    flush_ok = 1'b1;
    flush_tok.start_pos = stt_pkg::clamp16(token_start);
    flush_tok.token_length = 16'(token_count_len);
    unique case (mode)
      stt_pkg::MODE_WORD: flush_tok.token_kind = wkind;
      stt_pkg::MODE_NUM: flush_tok.token_kind = stt_pkg::K_NUMBER;
      stt_pkg::MODE_STR: flush_tok.token_kind = stt_pkg::K_BAD;
      stt_pkg::MODE_OP: begin
        flush_tok.token_length = 16'd1;
        unique case (pending_operator)
          stt_pkg::CH_EQ: flush_tok.token_kind = stt_pkg::K_ASSIGN;
          stt_pkg::CH_GT: flush_tok.token_kind = stt_pkg::K_GT;
          stt_pkg::CH_LT: flush_tok.token_kind = stt_pkg::K_LT;
          default: flush_tok.token_kind = stt_pkg::K_BAD;
        endcase
      end
      default: flush_ok = 1'b0;
    endcase
  end

  // Main scan step.
  always_comb begin
    mode_next = mode;
    pending_operator_next = pending_operator;
    position_counter_next = position_counter;
    token_start_next = token_start;
    token_count_len_next = token_count_len;
    wb_we = 1'b0;
    wb_addr = '0;
    n_flush = 1'b0;
    n_start = 1'b0;
    n_end = 1'b0;
    direct_ok = 1'b0;
    direct_tok = '0;
    start_tok = '0;
    start_emit = 1'b0;
    end_tok = '0;
    is_end = in_item.is_end || c == stt_pkg::CH_NUL;

    // Start of a new token, from idle or after a flushed token.
    start_tok.start_pos = stt_pkg::clamp16(p);
    start_tok.token_length = 16'd1;
    start_tok.token_kind = stt_pkg::K_BAD;
    priority if (c == "+") begin
      start_emit = 1'b1; start_tok.token_kind = stt_pkg::K_PLUS;
    end else if (c == "-") begin
      start_emit = 1'b1; start_tok.token_kind = stt_pkg::K_MINUS;
    end else if (c == "*") begin
      start_emit = 1'b1; start_tok.token_kind = stt_pkg::K_STAR;
    end else if (c == "/") begin
      start_emit = 1'b1; start_tok.token_kind = stt_pkg::K_SLASH;
    end else if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB ||
                 c == stt_pkg::CH_CR || c == stt_pkg::CH_LF ||
                 stt_pkg::is_letter(c) || stt_pkg::is_digit(c) ||
                 c == stt_pkg::CH_QUOTE || c == stt_pkg::CH_BANG ||
                 c == stt_pkg::CH_EQ || c == stt_pkg::CH_GT ||
                 c == stt_pkg::CH_LT) begin
      start_emit = 1'b0;
    end else begin
      start_emit = 1'b1;
    end

    end_tok.token_kind = stt_pkg::K_END;
    end_tok.start_pos = stt_pkg::clamp16(p);

    if (in_valid) begin
      if (is_end) begin
        n_flush = flush_ok;
        n_end = 1'b1;
        mode_next = stt_pkg::MODE_IDLE;
        position_counter_next = '0;
        token_count_len_next = '0;
        pending_operator_next = '0;
      end else begin
        if (position_counter != stt_pkg::POS_MAX)
          position_counter_next = position_counter + 1'b1;
        n_start = 1'b1;
        unique case (mode)
          stt_pkg::MODE_WORD: begin
            if (stt_pkg::is_letter(c)) begin
              n_start = 1'b0;
              if (token_count_len < stt_pkg::LEN_BITS'(stt_pkg::KEYWORD_MAX)) begin
                wb_we = 1'b1;
                wb_addr = stt_pkg::KIDX_BITS'(token_count_len);
              end
              token_count_len_next = len_inc;
            end else begin
              n_flush = 1'b1;
            end
          end
          stt_pkg::MODE_NUM: begin
            if (stt_pkg::is_digit(c)) begin
              n_start = 1'b0;
              token_count_len_next = len_inc;
            end else begin
              n_flush = 1'b1;
            end
          end
          stt_pkg::MODE_STR: begin
            n_start = 1'b0;
            token_count_len_next = len_inc;
            if (c == stt_pkg::CH_QUOTE) begin
              direct_ok = 1'b1;
              direct_tok.token_kind = stt_pkg::K_STRING;
              direct_tok.start_pos = stt_pkg::clamp16(token_start);
              direct_tok.token_length = 16'(len_inc);
              mode_next = stt_pkg::MODE_IDLE;
            end
          end
          stt_pkg::MODE_OP: begin
            if (c == stt_pkg::CH_EQ) begin
              n_start = 1'b0;
              direct_ok = 1'b1;
              direct_tok.start_pos = stt_pkg::clamp16(token_start);
              direct_tok.token_length = 16'd2;
              unique case (pending_operator)
                stt_pkg::CH_BANG: direct_tok.token_kind = stt_pkg::K_NE;
                stt_pkg::CH_EQ: direct_tok.token_kind = stt_pkg::K_EQEQ;
                stt_pkg::CH_GT: direct_tok.token_kind = stt_pkg::K_GE;
                default: direct_tok.token_kind = stt_pkg::K_LE;
              endcase
              mode_next = stt_pkg::MODE_IDLE;
            end else begin
              n_flush = 1'b1;
            end
          end
          default: ;
        endcase
        if (n_start) begin
          mode_next = stt_pkg::MODE_IDLE;
          token_start_next = p;
          token_count_len_next = stt_pkg::LEN_BITS'(1);
          priority if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB ||
                       c == stt_pkg::CH_CR || c == stt_pkg::CH_LF) begin
            token_count_len_next = '0;
          end else if (stt_pkg::is_letter(c)) begin
            mode_next = stt_pkg::MODE_WORD;
            wb_we = 1'b1;
            wb_addr = '0;
          end else if (stt_pkg::is_digit(c)) begin
            mode_next = stt_pkg::MODE_NUM;
          end else if (c == stt_pkg::CH_QUOTE) begin
            mode_next = stt_pkg::MODE_STR;
          end else if (c == stt_pkg::CH_BANG || c == stt_pkg::CH_EQ ||
                       c == stt_pkg::CH_GT || c == stt_pkg::CH_LT) begin
            mode_next = stt_pkg::MODE_OP;
            pending_operator_next = c;
          end else begin
            mode_next = stt_pkg::MODE_IDLE;
          end
        end
      end
    end
  end

  // Pack up to two tokens in order and mark the last.
  always_comb begin
    stt_pkg::out_item_t a, b;
    logic have_a, have_b;
    a = '0;
    b = '0;
    have_a = 1'b0;
    have_b = 1'b0;
    if (n_flush) begin
      a = flush_tok; have_a = 1'b1;
      if (n_end) begin
        b = end_tok; have_b = 1'b1;
      end else if (n_start && start_emit) begin
        b = start_tok; have_b = 1'b1;
      end
    end else if (n_end) begin
      a = end_tok; have_a = 1'b1;
    end else if (direct_ok) begin
      a = direct_tok; have_a = 1'b1;
    end else if (n_start && start_emit) begin
      a = start_tok; have_a = 1'b1;
    end
    a.last_of_run = !have_b;
    b.last_of_run = 1'b1;
    tok.two = have_b;
    tok.first = a;
    tok.second = b;
    tok_valid = have_a;
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stt_pkg::MODE_IDLE;
      pending_operator <= '0;
      position_counter <= '0;
      token_start <= '0;
      token_count_len <= '0;
    end else begin
      mode <= mode_next;
      pending_operator <= pending_operator_next;
      position_counter <= position_counter_next;
      token_start <= token_start_next;
      token_count_len <= token_count_len_next;
    end
  end

  // Word buffer, written one letter at a time.
  always_ff @(posedge clk) begin
    if (wb_we) word_buffer[wb_addr] <= c;
  end

endmodule

>>> rtl/stt_back.sv
// Token queue between scanner and result port; each entry holds one or two
// tokens, which are delivered one per transaction. Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  stt_pkg::tok_pair_t tok,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output stt_pkg::out_item_t res
);

  localparam int DEPTH = 4;
  localparam int AW = 2;

  stt_pkg::tok_pair_t store [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic half;
  logic do_push, do_pop, entry_done;

  // Input stalls only while every entry is taken.
  assign full = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign entry_done = do_pop && (!store[rd_ptr].two || half);
  assign res = half ? store[rd_ptr].second : store[rd_ptr].first;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= tok;
  end

  // Pointers, occupancy and second-token flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      half <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (entry_done) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(entry_done);
      if (entry_done) half <= 1'b0;
      else if (do_pop) half <= 1'b1;
    end
  end

endmodule

>>> rtl/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: scanner front end plus token queue.
// Depends on stt_pkg, stt_front and stt_back.
//
// Usage: bytes enter on the input queue port (push/full), one byte per
// transaction; is_end or a zero byte ends the stream. Tokens leave on the
// result queue port (empty/pop) as kind, start offset and length, with
// last_of_run set on the final token caused by a byte.
// Throughput: one byte per cycle while full is low; a byte causing two tokens
// needs two pops. A token is queued when its byte is accepted; tokens that
// need a lookahead byte (words, numbers, one-byte comparison operators) are
// reported when the next byte arrives.
// The queue holds four entries of up to two tokens each; when it is full,
// full rises and input stalls, while the scan state holds.
// Reset (rst, synchronous) empties the queue and returns the scanner to
// idle at offset 0. After an end the next byte starts again at offset 0.
`timescale 1ns / 1ps
module source_text_tokenizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  stt_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output stt_pkg::out_item_t out_item
);

  logic               in_acc;
  logic               tok_valid;
  stt_pkg::tok_pair_t tok;

  assign in_acc = push && !full;

  stt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_acc),
    .in_item   (in_item),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  stt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .push  (tok_valid),
    .tok   (tok),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .res   (out_item)
  );

  // An end token is always the last of its run.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.token_kind == stt_pkg::K_END) |-> out_item.last_of_run)
    else $error("end token not last of run");

  // End tokens carry zero length.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.token_kind == stt_pkg::K_END) |-> out_item.token_length == 16'd0)
    else $error("end token with nonzero length");

  // Results hold while stalled.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while stalled");

endmodule
